// ===== hdl/brtm_pkg.sv =====
// shared constants, command codes and types for the block ring transfer manager
`default_nettype none

package brtm_pkg;

    localparam logic [7:0] RING_BLOCKS = 8'd16;
    localparam logic [7:0] MAX_BURST   = 8'd4;
    localparam logic [7:0] BURST_CAP   = (MAX_BURST > 8'd127) ? 8'd127 : MAX_BURST;
    localparam logic [7:0] RING_MASK   = RING_BLOCKS - 8'd1;

    localparam logic [2:0] CMD_RESET   = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_DONE    = 3'd2;
    localparam logic [2:0] CMD_TAKE    = 3'd3;
    localparam logic [2:0] CMD_RELEASE = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;

    typedef struct packed {
        logic       valid;
        logic [6:0] slot;
        logic [6:0] count;
    } t_launch;

endpackage

`default_nettype wire

// ===== hdl/block_ring_transfer_manager.sv =====
// top level of the block ring transfer manager: command decode and counter update
`default_nettype none

// One command beat is accepted per clock cycle while the output side is not
// stalled. A beat is held in an input register, evaluated against the fill,
// take, release and remaining counters in a single pass, and its result is
// registered into the output register once the output side can take it, so
// a new beat can be accepted as the previous beat's result moves out. That
// single counter update path advances the ring state once per beat. The card
// addressing mode register may only be written while no beat is pending.
module block_ring_transfer_manager
    import brtm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_start_block,
    input  wire logic [31:0] i_block_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_issue_valid,
    output logic [6:0]       o_issue_slot,
    output logic [6:0]       o_issue_count,
    output logic             o_read_command_valid,
    output logic             o_multi_block,
    output logic [31:0]      o_card_address,
    output logic [7:0]       o_available_blocks,
    output logic [6:0]       o_take_slot,
    output logic             o_error
);

    function automatic t_launch f_launch(input logic [31:0] rem, input logic [7:0] fill,
                                         input logic [7:0] rel);
        logic [7:0] n;
        logic [7:0] used;
        logic [7:0] free;
        logic [7:0] idx;
        logic [7:0] lim;
        t_launch    l;
        l    = '0;
        n    = (rem > {24'd0, BURST_CAP}) ? BURST_CAP : rem[7:0];
        used = fill - rel;
        free = RING_BLOCKS - used;
        idx  = fill & RING_MASK;
        lim  = RING_BLOCKS - idx;
        if (n > free) n = free;
        if (n > lim) n = lim;
        if (rem != 32'd0 && used < RING_BLOCKS) begin
            l.valid = 1'b1;
            l.slot  = idx[6:0];
            l.count = n[6:0];
        end
        return l;
    endfunction

    // filled blocks from the take point up to the ring end
    function automatic logic [7:0] f_avail(input logic [7:0] take, input logic [7:0] fill);
        logic [7:0] e;
        logic [7:0] m;
        e = (take + RING_BLOCKS) & ~RING_MASK;
        m = ((e - fill) <= RING_BLOCKS) ? fill : e;
        return m - take;
    endfunction

    logic        r_hc;
    logic        r_in_valid;
    logic [2:0]  r_cmd;
    logic [31:0] r_start;
    logic [31:0] r_count;

    logic [31:0] r_rem,   n_rem;
    logic [7:0]  r_fill,  n_fill;
    logic [7:0]  r_take,  n_take;
    logic [7:0]  r_rel,   n_rel;
    logic [7:0]  r_burst, n_burst;

    logic        r_out_valid;
    logic        r_issue_valid, n_issue_valid;
    logic [6:0]  r_issue_slot,  n_issue_slot;
    logic [6:0]  r_issue_count, n_issue_count;
    logic        r_read_valid,  n_read_valid;
    logic        r_multi,       n_multi;
    logic [31:0] r_addr,        n_addr;
    logic [7:0]  r_avail,       n_avail;
    logic [6:0]  r_take_slot,   n_take_slot;
    logic        r_error,       n_error;

    logic        w_move;
    logic [7:0]  w_held;
    logic [7:0]  w_rel_n;
    t_launch     w_launch;

    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_move;

    always_comb begin
        n_rem         = r_rem;
        n_fill        = r_fill;
        n_take        = r_take;
        n_rel         = r_rel;
        n_burst       = r_burst;
        n_read_valid  = 1'b0;
        n_multi       = 1'b0;
        n_addr        = 32'd0;
        n_take_slot   = 7'd0;
        n_error       = 1'b0;
        w_launch      = '0;
        w_held        = r_take - r_rel;
        w_rel_n       = (r_count > {24'd0, w_held}) ? w_held : r_count[7:0];
        unique case (r_cmd)
            CMD_RESET: begin
                n_rem   = 32'd0;
                n_fill  = 8'd0;
                n_take  = 8'd0;
                n_rel   = 8'd0;
                n_burst = 8'd0;
            end
            CMD_START: begin
                if (r_count != 32'd0 && r_burst == 8'd0) begin
                    n_rem        = r_count;
                    w_launch     = f_launch(r_count, r_fill, r_rel);
                    n_read_valid = 1'b1;
                    n_multi      = (r_count != 32'd1);
                    n_addr       = r_hc ? r_start : {r_start[22:0], 9'd0};
                end
            end
            CMD_DONE: begin
                if (r_burst == 8'd0) begin
                    n_error = 1'b1;
                end else begin
                    n_fill   = r_fill + r_burst;
                    n_rem    = ({24'd0, r_burst} <= r_rem) ? r_rem - {24'd0, r_burst} : 32'd0;
                    n_burst  = 8'd0;
                    w_launch = f_launch(n_rem, n_fill, r_rel);
                end
            end
            CMD_TAKE: begin
                if (r_count > {24'd0, f_avail(r_take, r_fill)}) begin
                    n_error = 1'b1;
                end else begin
                    n_take_slot = r_take[6:0] & RING_MASK[6:0];
                    n_take      = r_take + r_count[7:0];
                end
            end
            CMD_RELEASE: begin
                n_rel = r_rel + w_rel_n;
                // ring was full and stalled: restart the engine
                if ((r_fill - r_rel) == RING_BLOCKS && r_burst == 8'd0) begin
                    w_launch = f_launch(r_rem, r_fill, n_rel);
                end
            end
            default: begin
            end
        endcase
        if (w_launch.valid) begin
            n_burst = {1'b0, w_launch.count};
        end
        n_issue_valid = w_launch.valid;
        n_issue_slot  = w_launch.slot;
        n_issue_count = w_launch.count;
        n_avail       = f_avail(n_take, n_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc        <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rem       <= 32'd0;
            r_fill      <= 8'd0;
            r_take      <= 8'd0;
            r_rel       <= 8'd0;
            r_burst     <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_hc <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_move) begin
                r_rem   <= n_rem;
                r_fill  <= n_fill;
                r_take  <= n_take;
                r_rel   <= n_rel;
                r_burst <= n_burst;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd   <= i_command;
            r_start <= i_start_block;
            r_count <= i_block_count;
        end
        if (w_move) begin
            r_issue_valid <= n_issue_valid;
            r_issue_slot  <= n_issue_slot;
            r_issue_count <= n_issue_count;
            r_read_valid  <= n_read_valid;
            r_multi       <= n_multi;
            r_addr        <= n_addr;
            r_avail       <= n_avail;
            r_take_slot   <= n_take_slot;
            r_error       <= n_error;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_issue_valid        = r_issue_valid;
    assign o_issue_slot         = r_issue_slot;
    assign o_issue_count        = r_issue_count;
    assign o_read_command_valid = r_read_valid;
    assign o_multi_block        = r_multi;
    assign o_card_address       = r_addr;
    assign o_available_blocks   = r_avail;
    assign o_take_slot          = r_take_slot;
    assign o_error              = r_error;

    a_ring_not_overfilled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill - r_rel) <= RING_BLOCKS)
        else $error("ring holds more blocks than it has slots");

    a_burst_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst <= BURST_CAP)
        else $error("burst in flight exceeds the burst cap");

    a_issue_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_issue_valid) |-> (r_issue_count != 7'd0 && !r_error))
        else $error("launched burst is empty or flagged as error");

    a_reset_cmd_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && r_cmd == CMD_RESET) |=> (r_fill == 8'd0 && r_take == 8'd0
                                            && r_burst == 8'd0 && r_avail == 8'd0))
        else $error("reset command did not clear the ring state");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for block_ring_transfer_manager: directed table, random phases, self-checking
module tb;
    import brtm_pkg::*;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int         HOLD_LEN   = 300;
    localparam int         PHASE_LEN  = 321;

    typedef struct packed {
        logic        issue_valid;
        logic [6:0]  issue_slot;
        logic [6:0]  issue_count;
        logic        read_cmd;
        logic        multi_block;
        logic [31:0] card_addr;
        logic [7:0]  avail;
        logic [6:0]  take_slot;
        logic        error;
    } t_ring_status;

    typedef enum logic [1:0] {ROW_CHECKED, ROW_TYPED, ROW_MODE} t_row_kind;

    typedef struct {
        t_row_kind    kind;
        logic [2:0]   cmd;
        logic [31:0]  start;
        logic [31:0]  count;
        t_ring_status status;
        logic         mode;
    } t_stim_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic [2:0]  command = CMD_QUERY;
    logic [31:0] start_block = '0;
    logic [31:0] block_count = '0;
    logic        out_ready = 1'b0;

    wire         in_ready;
    wire         out_valid;
    wire         issue_valid;
    wire [6:0]   issue_slot;
    wire [6:0]   issue_count;
    wire         read_command_valid;
    wire         multi_block;
    wire [31:0]  card_address;
    wire [7:0]   available_blocks;
    wire [6:0]   take_slot;
    wire         error;

    block_ring_transfer_manager dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_command            (command),
        .i_start_block        (start_block),
        .i_block_count        (block_count),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_issue_valid        (issue_valid),
        .o_issue_slot         (issue_slot),
        .o_issue_count        (issue_count),
        .o_read_command_valid (read_command_valid),
        .o_multi_block        (multi_block),
        .o_card_address       (card_address),
        .o_available_blocks   (available_blocks),
        .o_take_slot          (take_slot),
        .o_error              (error)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("block_ring_transfer_manager: mismatch");
        $finish;
    end

    // predicted ring state
    logic        block_addressed = 1'b0;
    logic [31:0] blocks_left = '0;
    logic [7:0]  filled_cnt = '0;
    logic [7:0]  taken_cnt = '0;
    logic [7:0]  freed_cnt = '0;
    logic [7:0]  burst_len = '0;

    t_ring_status ring_status_q[$];
    t_stim_row    directed_rows[$];
    int           mismatches = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;
    bit           rx_hold_req = 1'b0;

    function automatic logic [7:0] ring_avail();
        logic [7:0] wrap_pt;
        logic [7:0] wrap_gap;
        logic [7:0] lim;
        wrap_pt = (taken_cnt + RING_BLOCKS) & ~RING_MASK;
        wrap_gap = wrap_pt - filled_cnt;
        lim = (wrap_gap <= RING_BLOCKS) ? filled_cnt : wrap_pt;
        return lim - taken_cnt;
    endfunction

    function automatic void launch_next(inout t_ring_status r);
        logic [31:0] n;
        logic [7:0]  used;
        logic [7:0]  room;
        logic [7:0]  idx;
        logic [7:0]  to_end;
        if (blocks_left == 0) return;
        n = blocks_left;
        if (n > {24'd0, MAX_BURST}) n = {24'd0, MAX_BURST};
        if (n > 127) n = 127;
        used = filled_cnt - freed_cnt;
        if (used >= RING_BLOCKS) return;
        room = RING_BLOCKS - used;
        if (n > {24'd0, room}) n = {24'd0, room};
        idx = filled_cnt & RING_MASK;
        to_end = RING_BLOCKS - idx;
        if (n > {24'd0, to_end}) n = {24'd0, to_end};
        burst_len = n[7:0];
        r.issue_valid = 1'b1;
        r.issue_slot = idx[6:0];
        r.issue_count = n[6:0];
    endfunction

    function automatic t_ring_status predict_ring_status(logic [2:0] cmd, logic [31:0] start,
                                                         logic [31:0] count);
        t_ring_status r;
        logic [7:0]   held;
        logic [7:0]   old_freed;
        logic [7:0]   n;
        logic [7:0]   span;
        r = '0;
        case (cmd)
            CMD_RESET: begin
                blocks_left = '0;
                filled_cnt = '0;
                taken_cnt = '0;
                freed_cnt = '0;
                burst_len = '0;
            end
            CMD_START: begin
                if (count != 0 && burst_len == 0) begin
                    blocks_left = count;
                    launch_next(r);
                    r.read_cmd = 1'b1;
                    r.multi_block = (count != 1);
                    r.card_addr = block_addressed ? start : {start[22:0], 9'd0};
                end
            end
            CMD_DONE: begin
                if (burst_len == 0) begin
                    r.error = 1'b1;
                end else begin
                    filled_cnt = filled_cnt + burst_len;
                    blocks_left = ({24'd0, burst_len} <= blocks_left)
                                  ? blocks_left - {24'd0, burst_len} : '0;
                    burst_len = '0;
                    launch_next(r);
                end
            end
            CMD_TAKE: begin
                if (count > {24'd0, ring_avail()}) begin
                    r.error = 1'b1;
                end else begin
                    r.take_slot = taken_cnt[6:0] & RING_MASK[6:0];
                    taken_cnt = taken_cnt + count[7:0];
                end
            end
            CMD_RELEASE: begin
                held = taken_cnt - freed_cnt;
                old_freed = freed_cnt;
                n = (count > {24'd0, held}) ? held : count[7:0];
                freed_cnt = freed_cnt + n;
                span = filled_cnt - old_freed;
                if (span == RING_BLOCKS && burst_len == 0) launch_next(r);
            end
            default: ;
        endcase
        r.avail = ring_avail();
        return r;
    endfunction

    function automatic t_ring_status mk_status(logic iv, logic [6:0] slot, logic [6:0] cnt,
                                               logic rd, logic mb, logic [31:0] addr,
                                               logic [7:0] av, logic [6:0] ts, logic er);
        t_ring_status r;
        r.issue_valid = iv;
        r.issue_slot = slot;
        r.issue_count = cnt;
        r.read_cmd = rd;
        r.multi_block = mb;
        r.card_addr = addr;
        r.avail = av;
        r.take_slot = ts;
        r.error = er;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t: %s is %0h, predicted %0h", $realtime, what, got, want);
    endtask

    task automatic check_status(input t_ring_status got, input t_ring_status want);
        if (got.issue_valid !== want.issue_valid)
            report_mismatch("issue_valid", got.issue_valid, want.issue_valid);
        if (got.issue_slot !== want.issue_slot)
            report_mismatch("issue_slot", got.issue_slot, want.issue_slot);
        if (got.issue_count !== want.issue_count)
            report_mismatch("issue_count", got.issue_count, want.issue_count);
        if (got.read_cmd !== want.read_cmd)
            report_mismatch("read_command_valid", got.read_cmd, want.read_cmd);
        if (got.multi_block !== want.multi_block)
            report_mismatch("multi_block", got.multi_block, want.multi_block);
        if (got.card_addr !== want.card_addr)
            report_mismatch("card_address", got.card_addr, want.card_addr);
        if (got.avail !== want.avail)
            report_mismatch("available_blocks", got.avail, want.avail);
        if (got.take_slot !== want.take_slot)
            report_mismatch("take_slot", got.take_slot, want.take_slot);
        if (got.error !== want.error)
            report_mismatch("error", got.error, want.error);
    endtask

    // result beats
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (ring_status_q.size() == 0) begin
                report_mismatch("unexpected result beat", 32'd1, 32'd0);
            end else begin
                check_status(mk_status(issue_valid, issue_slot, issue_count,
                                       read_command_valid, multi_block, card_address,
                                       available_blocks, take_slot, error),
                             ring_status_q.pop_front());
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
            end
            gap = rx_idle_on ? $urandom_range(0, 11) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    task automatic send_item(input logic [2:0] cmd, input logic [31:0] start,
                             input logic [31:0] count, input bit use_typed,
                             input t_ring_status typed);
        int           gap;
        t_ring_status pred;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        start_block <= start;
        block_count <= count;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred = predict_ring_status(cmd, start, count);
        ring_status_q.push_back(use_typed ? typed : pred);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ring_status_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_card_mode(input logic mode);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        block_addressed = mode;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [2:0] cmd,
                           input logic [31:0] start, input logic [31:0] count,
                           input t_ring_status status, input logic mode = 1'b0);
        t_stim_row row;
        row.kind = kind;
        row.cmd = cmd;
        row.start = start;
        row.count = count;
        row.status = status;
        row.mode = mode;
        directed_rows.push_back(row);
    endtask

    task automatic random_item();
        int          pick;
        int          sel;
        logic [2:0]  cmd;
        logic [31:0] start;
        logic [31:0] count;
        logic [7:0]  held;
        pick = $urandom_range(0, 99);
        sel = $urandom_range(0, 19);
        start = $urandom;
        count = '0;
        held = taken_cnt - freed_cnt;
        if (pick < 12) begin
            cmd = CMD_START;
            if (sel < 13) count = $urandom_range(2, 24);
            else if (sel < 16) count = 1;
            else if (sel < 18) count = $urandom_range(25, 300);
            else if (sel < 19) count = $urandom;
            else count = 0;
        end else if (pick < 43) begin
            cmd = CMD_DONE;
            count = $urandom;
        end else if (pick < 68) begin
            cmd = CMD_TAKE;
            if (sel < 16) count = $urandom_range(0, ring_avail());
            else if (sel < 18) count = ring_avail() + $urandom_range(1, 3);
            else count = $urandom;
        end else if (pick < 91) begin
            cmd = CMD_RELEASE;
            if (sel < 16) count = $urandom_range(0, held);
            else if (sel < 18) count = held + $urandom_range(1, 5);
            else count = $urandom;
        end else if (pick < 93) begin
            cmd = CMD_QUERY;
            count = $urandom;
        end else if (pick < 95) begin
            cmd = CMD_SPARE6;
        end else if (pick < 97) begin
            cmd = CMD_SPARE7;
        end else if (pick < 98) begin
            cmd = CMD_RESET;
        end else begin
            cmd = CMD_DONE;
        end
        send_item(cmd, start, count, 1'b0, '0);
    endtask

    initial begin
        t_ring_status z;
        t_ring_status err;
        z = '0;
        err = mk_status(0, 0, 0, 0, 0, 0, 0, 0, 1);

        add_row(ROW_TYPED, CMD_QUERY, 32'h0, 32'h0, z);
        add_row(ROW_TYPED, CMD_DONE, 32'h0, 32'h0, err);
        add_row(ROW_TYPED, CMD_TAKE, 32'h0, 32'h1, err);
        add_row(ROW_TYPED, CMD_TAKE, 32'h0, 32'h0, z);
        add_row(ROW_TYPED, CMD_START, 32'hFFFF_FFFF, 32'h0, z);
        add_row(ROW_TYPED, CMD_START, 32'h0080_0001, 32'd10,
                mk_status(1, 0, 4, 1, 1, 32'h0000_0200, 0, 0, 0));
        add_row(ROW_TYPED, CMD_START, 32'h1, 32'h1, z);
        add_row(ROW_CHECKED, CMD_DONE, 32'h0, 32'h0, z);
        add_row(ROW_CHECKED, CMD_TAKE, 32'h0, 32'hFFFF_FFFF, z);
        add_row(ROW_CHECKED, CMD_TAKE, 32'h0, 32'd3, z);
        add_row(ROW_CHECKED, CMD_RELEASE, 32'h0, 32'hFFFF_FFFF, z);
        add_row(ROW_CHECKED, CMD_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, z);
        add_row(ROW_CHECKED, CMD_SPARE7, 32'h0, 32'h0, z);
        add_row(ROW_TYPED, CMD_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, z);
        add_row(ROW_MODE, CMD_QUERY, 32'h0, 32'h0, z, 1'b1);
        add_row(ROW_TYPED, CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                mk_status(1, 0, 4, 1, 1, 32'hFFFF_FFFF, 0, 0, 0));
        repeat (4) add_row(ROW_CHECKED, CMD_DONE, 32'h0, 32'h0, z);
        // ring full: release with nothing taken, then take all and release to restart
        add_row(ROW_CHECKED, CMD_RELEASE, 32'h0, 32'd1, z);
        add_row(ROW_CHECKED, CMD_TAKE, 32'h0, 32'd16, z);
        add_row(ROW_CHECKED, CMD_RELEASE, 32'h0, 32'd2, z);
        add_row(ROW_CHECKED, CMD_RELEASE, 32'h0, 32'd1, z);
        add_row(ROW_TYPED, CMD_RESET, 32'h0, 32'h0, z);
        add_row(ROW_TYPED, CMD_START, 32'd7, 32'd1,
                mk_status(1, 0, 1, 1, 0, 32'd7, 0, 0, 0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_MODE)
                write_card_mode(directed_rows[i].mode);
            else
                send_item(directed_rows[i].cmd, directed_rows[i].start,
                          directed_rows[i].count, directed_rows[i].kind == ROW_TYPED,
                          directed_rows[i].status);
        end

        for (int phase = 0; phase < 6; phase++) begin
            write_card_mode(phase[0]);
            tx_idle_on = (phase != 1 && phase != 2 && phase != 4);
            rx_idle_on = (phase != 1 && phase != 3);
            if (phase == 2) rx_hold_req = 1'b1;
            for (int k = 0; k < PHASE_LEN; k++) begin
                random_item();
                if ($urandom_range(0, 99) == 0) drain();
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("block_ring_transfer_manager: match");
        else
            $display("block_ring_transfer_manager: mismatch");
        $finish;
    end

endmodule
